// ===== design/deq_pkg.sv =====
// deq_pkg: request mode and result status codes for the double-ended queue.
// Used by double_ended_queue_unit. No dependencies.
`default_nettype none

package deq_pkg;

   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;
   localparam int FIELD_W  = 32;
   localparam int FILL_W   = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_PEEK       = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_POP_EMPTY = 2'd1,
      STATUS_PUSH_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

endpackage : deq_pkg

`default_nettype wire

// ===== design/double_ended_queue_unit.sv =====
// double_ended_queue_unit: bounded deque in a ring buffer held in one synchronous RAM.
// Pushes, peeks, errors and pops that empty the queue answer straight from ST_IDLE; a pop that
// leaves elements waits in ST_READ, as the new front or back word comes from the RAM read port.
// Throughput: one request per cycle while the receiver does not stall; none is taken in ST_READ.
// Reset clears head, count, state and the result valid; RAM contents are left as they are.
// Depends on deq_pkg.
`default_nettype none

module double_ended_queue_unit #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [deq_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [deq_pkg::FIELD_W-1:0]    req_push_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [deq_pkg::FIELD_W-1:0]         rsp_popped_value,
   output logic [deq_pkg::FIELD_W-1:0]         rsp_front_value,
   output logic [deq_pkg::FIELD_W-1:0]         rsp_back_value,
   output logic [deq_pkg::FILL_W-1:0]          rsp_fill_count,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   output logic [deq_pkg::STATUS_W-1:0]        rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   // only the low 32 bits of a word ever reach the ports
   localparam int IW = (VALUE_WIDTH < deq_pkg::FIELD_W) ? VALUE_WIDTH : deq_pkg::FIELD_W;

   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

   function automatic logic [AW-1:0] wrap_slot(input logic [AW:0] s);
      logic [AW:0] r;
      r = (s >= DEPTH_X) ? (s - DEPTH_X) : s;
      return r[AW-1:0];
   endfunction

   // ring buffer storage
   logic [IW-1:0] store_mem [DEPTH];
   logic [IW-1:0] rd_data_ff;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;

   deq_pkg::state_type state_ff, state_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      front_ff, front_in;
   logic [IW-1:0]      back_ff, back_in;
   logic               pend_front_ff, pend_front_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [deq_pkg::FIELD_W-1:0]   popped_ff, popped_in;
   logic [deq_pkg::FIELD_W-1:0]   front_out_ff, front_out_in;
   logic [deq_pkg::FIELD_W-1:0]   back_out_ff, back_out_in;
   logic [CW-1:0]                 fill_ff, fill_in;
   deq_pkg::status_type           status_ff, status_in;

   logic          accept;
   logic [IW-1:0] value;
   logic [AW:0]   cnt_x;
   logic [AW-1:0] head_inc;
   logic [AW-1:0] head_dec;
   logic [AW-1:0] tail_slot;
   logic [AW-1:0] back_prev_slot;
   logic          is_empty_now;
   logic          is_full_now;
   logic          wait_read;

   assign req_stall = !((state_ff == deq_pkg::ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;

   assign value          = IW'(req_push_value);
   assign cnt_x          = (AW + 1)'(count_ff);
   assign head_inc       = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign head_dec       = (head_ff == '0) ? LAST_SLOT : head_ff - 1'b1;
   assign tail_slot      = wrap_slot((AW + 1)'(head_ff) + cnt_x);
   // slot just before the back element, valid when two or more are held
   assign back_prev_slot = wrap_slot((AW + 1)'(head_ff) + cnt_x - (AW + 1)'(2));
   assign is_empty_now   = (count_ff == '0);
   assign is_full_now    = (count_ff >= DEPTH_C);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      pend_front_in = pend_front_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = head_dec;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = head_inc;
      wait_read     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      popped_in     = popped_ff;
      front_out_in  = front_out_ff;
      back_out_in   = back_out_ff;
      fill_in       = fill_ff;
      status_in     = status_ff;

      unique case (state_ff)
         deq_pkg::ST_IDLE: begin
            if (accept) begin
               popped_in = '0;
               status_in = deq_pkg::STATUS_OK;
               unique case (req_mode)
                  deq_pkg::MODE_PUSH_FRONT: begin
                     if (is_full_now) begin
                        status_in = deq_pkg::STATUS_PUSH_FULL;
                     end else begin
                        head_in     = head_dec;
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = head_dec;
                        front_in    = value;
                        if (is_empty_now) begin
                           back_in = value;
                        end
                        count_in = count_ff + 1'b1;
                     end
                  end
                  deq_pkg::MODE_PUSH_BACK: begin
                     if (is_full_now) begin
                        status_in = deq_pkg::STATUS_PUSH_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = tail_slot;
                        back_in     = value;
                        if (is_empty_now) begin
                           front_in = value;
                        end
                        count_in = count_ff + 1'b1;
                     end
                  end
                  deq_pkg::MODE_POP_FRONT: begin
                     if (is_empty_now) begin
                        status_in = deq_pkg::STATUS_POP_EMPTY;
                     end else begin
                        popped_in = deq_pkg::FIELD_W'(front_ff);
                        head_in   = head_inc;
                        count_in  = count_ff - 1'b1;
                        if (count_ff != CW'(1)) begin
                           mem_rd_en     = 1'b1;
                           mem_rd_addr   = head_inc;
                           pend_front_in = 1'b1;
                           wait_read     = 1'b1;
                        end
                     end
                  end
                  deq_pkg::MODE_POP_BACK: begin
                     if (is_empty_now) begin
                        status_in = deq_pkg::STATUS_POP_EMPTY;
                     end else begin
                        popped_in = deq_pkg::FIELD_W'(back_ff);
                        count_in  = count_ff - 1'b1;
                        if (count_ff != CW'(1)) begin
                           mem_rd_en     = 1'b1;
                           mem_rd_addr   = back_prev_slot;
                           pend_front_in = 1'b0;
                           wait_read     = 1'b1;
                        end
                     end
                  end
                  default: begin
                     // peek, and the unused codes behave as peek
                  end
               endcase
               fill_in = count_in;
               if (wait_read) begin
                  state_in = deq_pkg::ST_READ;
               end else begin
                  rsp_valid_in = 1'b1;
                  front_out_in = (count_in != '0) ? deq_pkg::FIELD_W'(front_in) : '0;
                  back_out_in  = (count_in != '0) ? deq_pkg::FIELD_W'(back_in) : '0;
               end
            end
         end
         deq_pkg::ST_READ: begin
            // RAM word for the new front or back has arrived
            if (pend_front_ff) begin
               front_in = rd_data_ff;
            end else begin
               back_in = rd_data_ff;
            end
            rsp_valid_in = 1'b1;
            front_out_in = deq_pkg::FIELD_W'(front_in);
            back_out_in  = deq_pkg::FIELD_W'(back_in);
            state_in     = deq_pkg::ST_IDLE;
         end
         default: begin
            state_in = deq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         store_mem[mem_wr_addr] <= value;
      end
      if (mem_rd_en) begin
         rd_data_ff <= store_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      back_ff       <= back_in;
      pend_front_ff <= pend_front_in;
      popped_ff     <= popped_in;
      front_out_ff  <= front_out_in;
      back_out_ff   <= back_out_in;
      fill_ff       <= fill_in;
      status_ff     <= status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_front_value  = front_out_ff;
   assign rsp_back_value   = back_out_ff;
   assign rsp_fill_count   = deq_pkg::FILL_W'(fill_ff);
   assign rsp_is_empty     = (fill_ff == '0);
   assign rsp_is_full      = (fill_ff >= DEPTH_C);
   assign rsp_status       = status_ff;

endmodule : double_ended_queue_unit

`default_nettype wire

// ===== tb/sv/double_ended_queue_unit_tb.sv =====
// Self-checking bench for double_ended_queue_unit: pushes, pops and peeks at both ends,
// checked word by word against a shadow deque kept in the bench. Depends on deq_pkg.
`timescale 1ns / 1ps

module double_ended_queue_unit_tb;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int HOLD_CYCLES = 200;

   // codes outside the enum behave as a peek
   localparam logic [deq_pkg::MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
   localparam logic [deq_pkg::MODE_W-1:0] MODE_SPARE_MID = 3'd6;
   localparam logic [deq_pkg::MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

   typedef struct packed {
      logic [deq_pkg::MODE_W-1:0]  mode;
      logic [deq_pkg::FIELD_W-1:0] value;
   } deq_req_type;

   typedef struct packed {
      logic [deq_pkg::FIELD_W-1:0] popped;
      logic [deq_pkg::FIELD_W-1:0] front;
      logic [deq_pkg::FIELD_W-1:0] back;
      logic [deq_pkg::FILL_W-1:0]  fill;
      logic                        empty;
      logic                        full;
      deq_pkg::status_type         status;
   } deq_rsp_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [deq_pkg::MODE_W-1:0]   req_mode = '0;
   logic [deq_pkg::FIELD_W-1:0]  req_push_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [deq_pkg::FIELD_W-1:0]  rsp_popped_value;
   logic [deq_pkg::FIELD_W-1:0]  rsp_front_value;
   logic [deq_pkg::FIELD_W-1:0]  rsp_back_value;
   logic [deq_pkg::FILL_W-1:0]   rsp_fill_count;
   logic                         rsp_is_empty;
   logic                         rsp_is_full;
   logic [deq_pkg::STATUS_W-1:0] rsp_status;

   deq_req_type req_backlog[$];
   deq_rsp_type rsp_due[$];
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   logic        hold_req = 1'b0;
   int unsigned hold_left = 0;
   int unsigned mismatches = 0;

   // shadow deque
   logic [deq_pkg::FIELD_W-1:0] shadow_store[DEPTH];
   int unsigned                 shadow_head = 0;
   int unsigned                 shadow_count = 0;

   double_ended_queue_unit #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_push_value   (req_push_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_popped_value (rsp_popped_value),
      .rsp_front_value  (rsp_front_value),
      .rsp_back_value   (rsp_back_value),
      .rsp_fill_count   (rsp_fill_count),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full),
      .rsp_status       (rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int unsigned ring_slot(input int unsigned offset);
      return (shadow_head + offset) % DEPTH;
   endfunction

   // apply one request to the shadow deque and queue the word it should produce
   task automatic deque_predict(input logic [deq_pkg::MODE_W-1:0] m,
                                input logic [deq_pkg::FIELD_W-1:0] v);
      deq_rsp_type w;
      w = '0;
      case (m)
         deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
            if (shadow_count >= DEPTH) begin
               w.status = deq_pkg::STATUS_PUSH_FULL;
            end else if (m == deq_pkg::MODE_PUSH_FRONT) begin
               shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
               shadow_store[shadow_head] = v;
               shadow_count++;
            end else begin
               shadow_store[ring_slot(shadow_count)] = v;
               shadow_count++;
            end
         end
         deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK: begin
            if (shadow_count == 0) begin
               w.status = deq_pkg::STATUS_POP_EMPTY;
            end else if (m == deq_pkg::MODE_POP_FRONT) begin
               w.popped = shadow_store[shadow_head];
               shadow_head = (shadow_head + 1) % DEPTH;
               shadow_count--;
            end else begin
               w.popped = shadow_store[ring_slot(shadow_count - 1)];
               shadow_count--;
            end
         end
         default: ;
      endcase
      if (shadow_count != 0) begin
         w.front = shadow_store[shadow_head];
         w.back  = shadow_store[ring_slot(shadow_count - 1)];
      end
      w.fill  = shadow_count[deq_pkg::FILL_W-1:0];
      w.empty = (shadow_count == 0);
      w.full  = (shadow_count >= DEPTH);
      rsp_due.push_back(w);
   endtask

   task automatic report_mismatch(input string what, input logic [deq_pkg::FIELD_W-1:0] got,
                                  input logic [deq_pkg::FIELD_W-1:0] want);
      if (mismatches < 40)
         $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // driver: a new word is offered only once the previous one has gone
   always @(posedge clock) begin : drive
      deq_req_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            item = req_backlog.pop_front();
            req_valid      <= 1'b1;
            req_mode       <= item.mode;
            req_push_value <= item.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         rsp_stall <= 1'b0;
      end else begin
         if (hold_req && hold_left == 0)
            hold_left <= HOLD_CYCLES;
         else if (hold_left != 0)
            hold_left <= hold_left - 1;
         rsp_stall <= hold_req || hold_left > 1 || ($urandom_range(0, 99) < stall_pct);
      end
   end

   // monitor: check the outgoing word first, then predict from the incoming one
   always @(posedge clock) begin : watch
      deq_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_due.size() == 0) begin
               report_mismatch("unexpected word", rsp_front_value, '0);
            end else begin
               want = rsp_due.pop_front();
               if (rsp_popped_value !== want.popped)
                  report_mismatch("popped_value", rsp_popped_value, want.popped);
               if (rsp_front_value !== want.front)
                  report_mismatch("front_value", rsp_front_value, want.front);
               if (rsp_back_value !== want.back)
                  report_mismatch("back_value", rsp_back_value, want.back);
               if (rsp_fill_count !== want.fill)
                  report_mismatch("fill_count", rsp_fill_count, want.fill);
               if (rsp_is_empty !== want.empty)
                  report_mismatch("is_empty", rsp_is_empty, want.empty);
               if (rsp_is_full !== want.full)
                  report_mismatch("is_full", rsp_is_full, want.full);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
            end
         end
         if (req_valid && !req_stall)
            deque_predict(req_mode, req_push_value);
      end
   end

   task automatic add_req(input logic [deq_pkg::MODE_W-1:0] m,
                          input logic [deq_pkg::FIELD_W-1:0] v);
      deq_req_type item;
      item.mode  = m;
      item.value = v;
      req_backlog.push_back(item);
   endtask

   function automatic logic [deq_pkg::FIELD_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // a run of requests leaning towards pushes or pops so both ends of the fill are hit
   task automatic add_burst(input int n, input int unsigned push_pct);
      int unsigned r;
      logic [deq_pkg::MODE_W-1:0] m;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 5)
            m = deq_pkg::MODE_W'($urandom_range(deq_pkg::MODE_PEEK, MODE_SPARE_HI));
         else if (r < push_pct)
            m = deq_pkg::MODE_W'($urandom_range(deq_pkg::MODE_PUSH_FRONT,
                                                deq_pkg::MODE_PUSH_BACK));
         else
            m = deq_pkg::MODE_W'($urandom_range(deq_pkg::MODE_POP_FRONT,
                                                deq_pkg::MODE_POP_BACK));
         add_req(m, pick_value());
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0);
   endtask

   task automatic run_phase(input int unsigned idle, input int unsigned stall, input int n);
      int left;
      int len;
      idle_pct  = idle;
      stall_pct = stall;
      left = n;
      while (left > 0) begin
         len = $urandom_range(8, 32);
         if (len > left) len = left;
         case ($urandom_range(0, 2))
            0:       add_burst(len, 80);
            1:       add_burst(len, 50);
            default: add_burst(len, 20);
         endcase
         left -= len;
      end
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty queue: both pops fail, spare code acts as a peek; then one push and one pop at each end
      add_req(deq_pkg::MODE_POP_FRONT, 32'h1234_5678);
      add_req(deq_pkg::MODE_POP_BACK, '1);
      add_req(MODE_SPARE_LO, '1);
      add_req(deq_pkg::MODE_PUSH_FRONT, '0);
      add_req(deq_pkg::MODE_PUSH_BACK, '1);
      add_req(deq_pkg::MODE_POP_FRONT, '0);
      add_req(deq_pkg::MODE_POP_BACK, '0);
      // fill from both ends, push on full at either end, then peek, also with the spare codes
      for (int i = 0; i < DEPTH; i++)
         add_req(i[0] ? deq_pkg::MODE_PUSH_BACK : deq_pkg::MODE_PUSH_FRONT, $urandom);
      add_req(deq_pkg::MODE_PUSH_FRONT, 32'hA5A5_A5A5);
      add_req(deq_pkg::MODE_PUSH_BACK, 32'h5A5A_5A5A);
      add_req(deq_pkg::MODE_PEEK, '0);
      add_req(MODE_SPARE_MID, '0);
      add_req(MODE_SPARE_HI, '1);
      wait_drained();

      // long hold-off at the receiver while the sender keeps offering
      idle_pct  = 0;
      stall_pct = 0;
      hold_req  = 1'b1;
      add_burst(48, 50);
      while (hold_left == 0) @(negedge clock);
      hold_req = 1'b0;
      wait_drained();

      run_phase(0, 0, 150);
      run_phase(65, 0, 150);
      run_phase(0, 65, 150);
      run_phase(33, 33, 150);

      repeat (10) @(negedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/deq_pkg.sv
design/double_ended_queue_unit.sv
tb/sv/double_ended_queue_unit_tb.sv
